@@ sv/nwst_pkg.sv @@
// Shared types, constants and the tanh table of the neuron weighted-sum unit.
`timescale 1ns / 1ps
package nwst_pkg;

  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = 24;
  localparam int ACT_W     = 16;
  localparam int FRAC_BITS = 12;
  localparam int IDX_W     = 6;
  localparam int CNT_CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 2'd1;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_ELEMENT = 1'b1;

  // element entering the datapath
  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic                     acc_en;
    logic                     err;
    logic signed [DATA_W-1:0] value;
  } nwst_elem_t;

  // closed vector leaving the accumulator
  typedef struct packed {
    logic                    vld;
    logic                    err;
    logic signed [ACC_W-1:0] acc;
  } nwst_acc_t;

  // round(16384 * tanh(k/8)), k = 0..32
  function automatic logic [13:0] tanh_lut(input logic [5:0] k);
    logic [13:0] v;
    case (k)
      6'd0:  v = 14'd0;
      6'd1:  v = 14'd2037;
      6'd2:  v = 14'd4013;
      6'd3:  v = 14'd5871;
      6'd4:  v = 14'd7571;
      6'd5:  v = 14'd9087;
      6'd6:  v = 14'd10406;
      6'd7:  v = 14'd11533;
      6'd8:  v = 14'd12478;
      6'd9:  v = 14'd13260;
      6'd10: v = 14'd13898;
      6'd11: v = 14'd14415;
      6'd12: v = 14'd14830;
      6'd13: v = 14'd15161;
      6'd14: v = 14'd15423;
      6'd15: v = 14'd15631;
      6'd16: v = 14'd15795;
      6'd17: v = 14'd15923;
      6'd18: v = 14'd16024;
      6'd19: v = 14'd16103;
      6'd20: v = 14'd16165;
      6'd21: v = 14'd16213;
      6'd22: v = 14'd16251;
      6'd23: v = 14'd16280;
      6'd24: v = 14'd16303;
      6'd25: v = 14'd16321;
      6'd26: v = 14'd16335;
      6'd27: v = 14'd16346;
      6'd28: v = 14'd16354;
      6'd29: v = 14'd16361;
      6'd30: v = 14'd16366;
      6'd31: v = 14'd16370;
      6'd32: v = 14'd16373;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/nwst_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module nwst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/nwst_mac.sv @@
// Weight store with per-entry valid bits, multiplier and saturating accumulator.
`timescale 1ns / 1ps
module nwst_mac #(
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          advance,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [nwst_pkg::DATA_W-1:0]                   wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  nwst_pkg::nwst_elem_t                          elem,
  output nwst_pkg::nwst_acc_t                           res
);
  import nwst_pkg::*;

  logic [DEPTH-1:0]         wvalid;
  logic                     rd_en;
  logic [DATA_W-1:0]        ram_q;
  logic                     p1_wv;
  nwst_elem_t               p1;
  nwst_elem_t               p2;
  logic signed [DATA_W-1:0] weight;
  logic signed [PROD_W-1:0] p2_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic signed [ACC_W-1:0]  acc_next;

  assign rd_en = advance && elem.vld;

  nwst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_wram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // never-written entries read as zero
  assign weight = p1_wv ? $signed(ram_q) : '0;

  assign acc_sum = {acc[ACC_W-1], acc} +
                   {{(ACC_W + 1 - PROD_W){p2_prod[PROD_W-1]}}, p2_prod};

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
    acc_next = p2.acc_en ? acc_sat : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (wr_en) begin
      wvalid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_wv <= wvalid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1      <= '0;
      p2      <= '0;
      p2_prod <= '0;
      acc     <= '0;
      res     <= '0;
    end else if (advance) begin
      p1      <= elem;
      p2      <= p1;
      p2_prod <= weight * p1.value;
      res.vld <= p2.vld && p2.last;
      res.err <= p2.err;
      res.acc <= acc_next;
      if (p2.vld) begin
        acc <= p2.last ? '0 : acc_next;
      end
    end
  end

endmodule

@@ sv/nwst_act.sv @@
// Bias add, Q12.12 rounding and saturation, tanh interpolation and output register.
`timescale 1ns / 1ps
module nwst_act (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [nwst_pkg::DATA_W-1:0]  bias,
  input  nwst_pkg::nwst_acc_t                 acc_in,
  input  logic                                m_tready,
  output logic                                advance,
  output logic                                out_valid,
  output logic signed [nwst_pkg::SUM_W-1:0]   out_sum,
  output logic signed [nwst_pkg::ACT_W-1:0]   out_act,
  output logic                                out_err
);
  import nwst_pkg::*;

  localparam int WIDE_W = ACC_W + 2;
  localparam int SHR_W  = WIDE_W - FRAC_BITS;
  localparam logic [WIDE_W-1:0] HALF_LSB  = WIDE_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]  TAIL_START = SUM_W'(16384);
  localparam logic [SUM_W-1:0]  SAT_START  = SUM_W'(20480);
  localparam logic [14:0] ONE_Q14    = 15'd16384;
  localparam logic [14:0] TAIL_BASE  = 15'd16373;
  localparam logic [11:0] TAIL_SLOPE = 12'd11;

  logic signed [WIDE_W-1:0] total;
  logic signed [SHR_W-1:0]  shifted;
  logic signed [SUM_W-1:0]  sum_sat;

  logic                    p4_vld;
  logic                    p4_err;
  logic signed [SUM_W-1:0] p4_sum;

  logic [SUM_W-1:0] mag;
  logic [4:0]       seg;
  logic [13:0]      lo;
  logic [13:0]      hi;
  logic [14:0]      base_c;
  logic [11:0]      delta_c;
  logic [11:0]      frac_c;
  logic             fine_c;

  logic                    p5_vld;
  logic                    p5_err;
  logic                    p5_neg;
  logic signed [SUM_W-1:0] p5_sum;
  logic [14:0]             p5_base;
  logic [11:0]             p5_delta;
  logic [11:0]             p5_frac;
  logic                    p5_fine;

  logic [23:0]             prod;
  logic [14:0]             inc;
  logic [14:0]             y;
  logic signed [ACT_W-1:0] act_c;
  logic                    load;
  logic signed [ACT_W-1:0] held;

  function automatic logic [23:0] delta_c_reg_mul(input logic [11:0] a, input logic [11:0] b);
    return a * b;
  endfunction

  assign total = {{2{acc_in.acc[ACC_W-1]}}, acc_in.acc} +
                 {{(WIDE_W - DATA_W - FRAC_BITS){bias[DATA_W-1]}}, bias, {FRAC_BITS{1'b0}}} +
                 HALF_LSB;
  assign shifted = total[WIDE_W-1:FRAC_BITS];

  always_comb begin
    if (shifted[SHR_W-1:SUM_W-1] == {(SHR_W - SUM_W + 1){shifted[SHR_W-1]}}) begin
      sum_sat = shifted[SUM_W-1:0];
    end else begin
      sum_sat = shifted[SHR_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
  end

  // segment select: table interpolation below 4.0, linear tail to 5.0, flat above
  always_comb begin
    mag     = p4_sum[SUM_W-1] ? (~p4_sum + 1'b1) : p4_sum;
    seg     = mag[13:9];
    lo      = tanh_lut({1'b0, seg});
    hi      = tanh_lut({1'b0, seg} + 6'd1);
    base_c  = {1'b0, lo};
    delta_c = 12'(hi - lo);
    frac_c  = {3'b0, mag[8:0]};
    fine_c  = 1'b1;
    if (mag >= SAT_START) begin
      base_c  = ONE_Q14;
      delta_c = '0;
      frac_c  = '0;
      fine_c  = 1'b0;
    end else if (mag >= TAIL_START) begin
      base_c  = TAIL_BASE;
      delta_c = TAIL_SLOPE;
      frac_c  = mag[11:0];
      fine_c  = 1'b0;
    end
  end

  always_comb begin
    prod  = delta_c_reg_mul(p5_delta, p5_frac);
    inc   = p5_fine ? 15'((prod + 24'd256) >> 9) : 15'((prod + 24'd2048) >> 12);
    y     = p5_base + inc;
    act_c = p5_neg ? -$signed({1'b0, y}) : $signed({1'b0, y});
  end

  assign advance = !(p5_vld && out_valid && !m_tready);
  assign load    = advance && p5_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld   <= 1'b0;
      p4_err   <= 1'b0;
      p4_sum   <= '0;
      p5_vld   <= 1'b0;
      p5_err   <= 1'b0;
      p5_neg   <= 1'b0;
      p5_sum   <= '0;
      p5_base  <= '0;
      p5_delta <= '0;
      p5_frac  <= '0;
      p5_fine  <= 1'b0;
    end else if (advance) begin
      p4_vld   <= acc_in.vld;
      p4_err   <= acc_in.err;
      p4_sum   <= sum_sat;
      p5_vld   <= p4_vld;
      p5_err   <= p4_err;
      p5_neg   <= p4_sum[SUM_W-1];
      p5_sum   <= p4_sum;
      p5_base  <= base_c;
      p5_delta <= delta_c;
      p5_frac  <= frac_c;
      p5_fine  <= fine_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_sum   <= '0;
      out_act   <= '0;
      out_err   <= 1'b0;
      held      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      out_sum   <= p5_err ? '0 : p5_sum;
      out_act   <= p5_err ? held : act_c;
      out_err   <= p5_err;
      if (!p5_err) begin
        held <= act_c;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ sv/neuron_weighted_sum_tanh_unit.sv @@
// Top level of the single-neuron weighted-sum and tanh unit.
//
// Slave stream: s_tuser is the command (write weight or present element),
// s_tdata carries index and value, s_tlast closes an input vector.
// Weight writes land in the weight store at the edge that takes the transaction;
// an element may follow a write to the same entry in the very next cycle.
// Elements multiply against the weight at the running element position.
// One item is taken every cycle while s_tready is high; the weight store read
// is addressed by the element counter and registered, then multiply, accumulate,
// bias/round, tanh segment select and interpolation each take one register.
// The result of a vector passes these registers after the transaction carrying
// s_tlast and then appears on the master stream: m_tdata holds weighted sum and
// activation, m_tuser the count error flag.
// The output register lets new items in while a result waits; the pipeline
// stalls only when a second result reaches the output while m_tready is low.
// Reset clears the weight store valid bits (weights read as zero), the
// accumulator, the element counter, the held activation and the registers.
// Configuration (bias, input_count) via cfg_*: user writes it only while idle, not enforced.
`timescale 1ns / 1ps
module neuron_weighted_sum_tanh_unit #(
  parameter int MAX_INPUTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,   // index[5:0], value[21:6], zero pad
  input  logic                               s_tuser,   // command
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [39:0]                        m_tdata,   // weighted_sum[23:0], activation[39:24]
  output logic                               m_tuser,   // error
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nwst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nwst_pkg::DATA_W-1:0]        cfg_data
);
  import nwst_pkg::*;

  localparam int AW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CNT_W = $clog2(MAX_INPUTS + 2);

  logic signed [DATA_W-1:0] bias;
  logic [CNT_CFG_W-1:0]     input_count;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         cnt_after;

  logic [IDX_W-1:0]         in_index;
  logic [DATA_W-1:0]        in_value;
  logic                     in_acc;
  logic                     elem_acc;
  logic                     wr_en;
  logic                     acc_en;
  logic                     cnt_err;
  logic [AW-1:0]            rd_addr;
  nwst_elem_t               elem;
  nwst_acc_t                acc_res;
  logic                     advance;
  logic signed [SUM_W-1:0]  out_sum;
  logic signed [ACT_W-1:0]  out_act;

  assign in_index = s_tdata[IDX_W-1:0];
  assign in_value = s_tdata[IDX_W +: DATA_W];

  assign s_tready  = advance && !rst;
  assign cfg_ready = !rst;

  assign in_acc   = s_tvalid && s_tready;
  assign elem_acc = in_acc && (s_tuser == CMD_ELEMENT);
  assign wr_en    = in_acc && (s_tuser == CMD_WRITE) && (32'(in_index) < MAX_INPUTS);

  assign acc_en    = 32'(count) < MAX_INPUTS;
  assign cnt_after = (32'(count) <= MAX_INPUTS) ? count + CNT_W'(1) : count;
  assign cnt_err   = (input_count == '0) || (32'(input_count) > MAX_INPUTS) ||
                     (32'(cnt_after) != 32'(input_count));
  assign rd_addr   = acc_en ? count[AW-1:0] : '0;

  always_comb begin
    elem.vld    = elem_acc;
    elem.last   = s_tlast;
    elem.acc_en = acc_en;
    elem.err    = cnt_err;
    elem.value  = $signed(in_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias        <= '0;
      input_count <= CNT_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIAS:        bias        <= $signed(cfg_data);
        CFG_INPUT_COUNT: input_count <= cfg_data[CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (elem_acc) begin
      count <= s_tlast ? '0 : cnt_after;
    end
  end

  nwst_mac #(
    .DEPTH(MAX_INPUTS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .wr_en  (wr_en),
    .wr_addr(AW'(in_index)),
    .wr_data(in_value),
    .rd_addr(rd_addr),
    .elem   (elem),
    .res    (acc_res)
  );

  nwst_act u_act (
    .clk      (clk),
    .rst      (rst),
    .bias     (bias),
    .acc_in   (acc_res),
    .m_tready (m_tready),
    .advance  (advance),
    .out_valid(m_tvalid),
    .out_sum  (out_sum),
    .out_act  (out_act),
    .out_err  (m_tuser)
  );

  assign m_tdata = {out_act, out_sum};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_INPUTS + 1)
    else $error("element counter beyond saturation point");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    elem_acc && s_tlast |=> count == '0)
    else $error("element counter not cleared after last element");

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      $signed(m_tdata[39:24]) <= 16'sd16384 && $signed(m_tdata[39:24]) >= -16'sd16384)
    else $error("activation outside Q1.14 unit range");

  a_act_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[23] |-> m_tdata[39] || m_tdata[39:24] == '0)
    else $error("activation sign does not follow weighted sum");

endmodule
